FILE: hw/rtl/u2u_pkg.sv
// shared types, codes and constants for the utf-8 to ucs transcoder
// no dependencies
package u2u_pkg;

    // widths of the beat fields
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CODE_W   = 21;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned NEED_W   = 2;

    // result queue sizing
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_RAW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UCS2 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UCS4 = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_UTF8 = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED   = 2'd3;

    // byte constants
    localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;
    localparam logic [CODE_W-1:0] UCS2_MAX   = 21'h00FFFF;

    // input beat
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              is_last;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [CODE_W-1:0]   code_value;
        logic [STATUS_W-1:0] status;
        logic                end_of_string;
    } t_out_beat;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic      v0;
        logic      v1;
        t_out_beat beat0;
        t_out_beat beat1;
    } t_push;

endpackage

FILE: hw/rtl/u2u_decode.sv
// decode stage: string state registers and the per-byte decode logic
// depends on u2u_pkg
module u2u_decode
    import u2u_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_in_beat          i_beat,
    input  logic [MODE_W-1:0] i_mode,
    output t_push             o_push
);

    logic [CODE_W-1:0]   r_acc,  n_acc;
    logic [NEED_W-1:0]   r_need, n_need;
    logic                r_qp,   n_qp;
    logic [STATUS_W-1:0] r_err,  n_err;

    logic      q_v, h_v, e_v;
    t_out_beat q_beat, h_beat, e_beat;

    // per-byte decode
    always_comb begin
        logic [BYTE_W-1:0] b;
        logic              last;
        logic              raw;
        logic              done;
        logic [CODE_W-1:0] cv;

        b      = i_beat.in_byte;
        last   = i_beat.is_last;
        raw    = (i_mode != MODE_UCS2) && (i_mode != MODE_UCS4);
        done   = 1'b0;
        cv     = '0;
        n_acc  = r_acc;
        n_need = r_need;
        n_qp   = r_qp;
        n_err  = r_err;
        q_v    = 1'b0;
        h_v    = 1'b0;
        e_v    = 1'b0;
        q_beat = '{code_value: CODE_W'(QUOTE_BYTE), status: ST_OK, end_of_string: 1'b0};
        h_beat = '0;
        e_beat = '0;

        if (r_err != ST_OK) begin
            // sticky error: drop bytes, report on the last one
            done = 1'b1;
            if (last) begin
                e_v    = 1'b1;
                e_beat = '{code_value: '0, status: r_err, end_of_string: 1'b1};
            end
        end else if (r_need == '0 && r_qp) begin
            n_qp = 1'b0;
            q_v  = 1'b1;
            if (b == QUOTE_BYTE) begin
                // doubled quote collapses to one
                q_beat.end_of_string = last;
                done = 1'b1;
            end
        end else if (r_need == '0 && b == QUOTE_BYTE && !last) begin
            n_qp = 1'b1;
            done = 1'b1;
        end

        if (!done) begin
            if (raw) begin
                cv     = CODE_W'(b);
                h_v    = 1'b1;
                n_need = '0;
            end else if (r_need == '0) begin
                // lead byte
                if (b[7] == 1'b0) begin
                    cv  = CODE_W'(b);
                    h_v = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    n_acc  = CODE_W'(b[4:0]);
                    n_need = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    n_acc  = CODE_W'(b[3:0]);
                    n_need = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    n_acc  = CODE_W'(b[2:0]);
                    n_need = 2'd3;
                end else begin
                    n_err = ST_BAD_UTF8;
                end
            end else begin
                // continuation byte
                if (b[7:6] != 2'b10) begin
                    n_err = ST_BAD_UTF8;
                end else begin
                    n_acc  = {r_acc[CODE_W-7:0], b[5:0]};
                    n_need = r_need - 2'd1;
                    if (n_need == '0) begin
                        cv  = n_acc;
                        h_v = 1'b1;
                    end
                end
            end

            // ucs-2 range check
            if (h_v && i_mode == MODE_UCS2 && cv > UCS2_MAX) begin
                n_err = ST_RANGE;
                h_v   = 1'b0;
            end
            if (n_err == ST_OK && last && !h_v) begin
                n_err = ST_BAD_UTF8;
            end
            h_beat = '{code_value: cv, status: ST_OK, end_of_string: last};
            if (n_err != ST_OK && last) begin
                e_v    = 1'b1;
                e_beat = '{code_value: '0, status: n_err, end_of_string: 1'b1};
            end
        end

        // end of string clears everything
        if (last) begin
            n_acc  = '0;
            n_need = '0;
            n_qp   = 1'b0;
            n_err  = ST_OK;
        end
    end

    // pack up to two results in order
    always_comb begin
        o_push.v0    = i_fire && (q_v || h_v || e_v);
        o_push.v1    = i_fire && q_v && (h_v || e_v);
        o_push.beat0 = q_v ? q_beat : (h_v ? h_beat : e_beat);
        o_push.beat1 = h_v ? h_beat : e_beat;
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_need <= '0;
            r_qp   <= 1'b0;
            r_err  <= ST_OK;
        end else if (i_fire) begin
            r_acc  <= n_acc;
            r_need <= n_need;
            r_qp   <= n_qp;
            r_err  <= n_err;
        end
    end

endmodule

FILE: hw/rtl/u2u_outq.sv
// result queue: takes up to two beats per cycle, one out per ready cycle
// depends on u2u_pkg
module u2u_outq
    import u2u_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room2,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    t_out_beat           r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_cnt,  n_cnt;
    logic                pop;
    logic [QPTR_W-1:0]   wptr1;

    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_mem[r_rptr];
    assign o_room2 = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wptr1   = r_wptr + QPTR_W'(1);

    // pointer and count updates
    always_comb begin
        n_wptr = r_wptr + QPTR_W'(i_push.v0) + QPTR_W'(i_push.v1);
        n_rptr = r_rptr + QPTR_W'(pop);
        n_cnt  = r_cnt + QCNT_W'(i_push.v0) + QCNT_W'(i_push.v1) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wptr] <= i_push.beat0;
        end
        if (i_push.v1) begin
            r_mem[wptr1] <= i_push.beat1;
        end
    end

endmodule

FILE: hw/rtl/utf8_to_ucs_transcoder.sv
// utf-8 to ucs transcoder for the body of a quoted string
// depends on u2u_pkg, u2u_decode and u2u_outq
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) carries one byte of the
//   string body per beat, with is_last on its final byte.
//   output channel (o_out_valid / i_out_ready / o_out_data) carries code units,
//   a status and an end_of_string flag; an error shows as one beat with code 0.
//   i_cfg_we / i_cfg_wdata write the mode (raw, ucs-2, ucs-4); write it only
//   while the block is idle.
// timing:
//   a byte is registered at its input beat, decoded from that register into a
//   four-entry result queue once the queue has room for two results, and
//   shows on the output straight from the queue.
//   one byte per cycle is taken as long as the queue keeps room for two
//   results; a byte that yields two results (a held quote plus the byte)
//   takes two entries; sustained rate is one result per cycle while ready.
// reset: synchronous, active low; clears the string state, the queue and
//   the mode (raw).
// stall: when the receiver holds i_out_ready low the queue fills, then the
//   input register holds and o_in_ready drops until room returns.
module utf8_to_ucs_transcoder
    import u2u_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_beat         o_out_data,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata
);

    logic [MODE_W-1:0] r_mode;
    logic              r_in_valid;
    t_in_beat          r_in;
    logic              room2;
    logic              fire;
    t_push             push;

    assign fire       = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || fire;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RAW;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    u2u_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_beat  (r_in),
        .i_mode  (r_mode),
        .o_push  (push)
    );

    u2u_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_data)
    );

endmodule

FILE: hw/rtl/u2u_checker.sv
// port-level checks for the utf-8 to ucs transcoder, bound to the top level
// depends on u2u_pkg
module u2u_checker
    import u2u_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input t_in_beat          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input t_out_beat         o_out_data
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat withdrawn while stalled");

    // a waiting input beat stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while waiting");

    // an error beat carries no code and closes the string
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.code_value == '0 && o_out_data.end_of_string)
        else $error("error beat with code or without end of string");

    // no unused status code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status != ST_UNUSED)
        else $error("unused status code on output");

    // input back-pressure only while results are waiting
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

endmodule

bind utf8_to_ucs_transcoder u2u_checker u_u2u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/testbench.sv
// self-checking testbench for utf8_to_ucs_transcoder: directed strings, then random strings
// in every mode, predicted in-line and checked beat by beat; depends on u2u_pkg and the rtl
module testbench;
    import u2u_pkg::*;

    // mode 3 has no meaning and must behave as raw passthrough
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_MAX   = 10;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_beat          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_beat         o_out_data;
    logic              i_cfg_we    = 1'b0;
    logic [MODE_W-1:0] i_cfg_wdata = MODE_RAW;

    // pending input beats and expected code units
    t_in_beat  byte_q[$];
    t_out_beat code_unit_q[$];

    // idling controls, set per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned fail_cnt = 0;

    // predicted decoder state
    logic [MODE_W-1:0]   cur_mode   = MODE_RAW;
    logic [CODE_W-1:0]   accum      = '0;
    logic [NEED_W-1:0]   need_cnt   = '0;
    logic                quote_held = 1'b0;
    logic [STATUS_W-1:0] err_code   = ST_OK;

    utf8_to_ucs_transcoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void push_unit(logic [CODE_W-1:0] code, logic [STATUS_W-1:0] st,
                                      logic eos);
        t_out_beat u;
        u.code_value    = code;
        u.status        = st;
        u.end_of_string = eos;
        code_unit_q.push_back(u);
    endfunction

    function automatic void clear_string();
        accum      = '0;
        need_cnt   = '0;
        quote_held = 1'b0;
        err_code   = ST_OK;
    endfunction

    // predict the code units caused by one accepted byte
    task automatic decode_byte(input t_in_beat beat);
        logic [7:0]        b;
        logic              last;
        logic              raw;
        logic              have;
        logic [CODE_W-1:0] cv;
        b    = beat.in_byte;
        last = beat.is_last;
        raw  = !(cur_mode == MODE_UCS2 || cur_mode == MODE_UCS4);
        have = 1'b0;
        cv   = '0;
        // sticky error: drop bytes, report on the last one
        if (err_code != ST_OK) begin
            if (last) begin
                push_unit('0, err_code, 1'b1);
                clear_string();
            end
            return;
        end
        // doubled quote handling at a code point boundary
        if (need_cnt == 0 && quote_held) begin
            quote_held = 1'b0;
            if (b == QUOTE_BYTE) begin
                push_unit(CODE_W'(QUOTE_BYTE), ST_OK, last);
                if (last)
                    clear_string();
                return;
            end
            push_unit(CODE_W'(QUOTE_BYTE), ST_OK, 1'b0);
        end else if (need_cnt == 0 && b == QUOTE_BYTE && !last) begin
            quote_held = 1'b1;
            return;
        end
        // byte decode
        if (raw) begin
            cv       = CODE_W'(b);
            have     = 1'b1;
            need_cnt = '0;
        end else if (need_cnt == 0) begin
            if (b < 8'h80) begin
                cv   = CODE_W'(b);
                have = 1'b1;
            end else if ((b & 8'hE0) == 8'hC0) begin
                accum    = CODE_W'(b & 8'h1F);
                need_cnt = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                accum    = CODE_W'(b & 8'h0F);
                need_cnt = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                accum    = CODE_W'(b & 8'h07);
                need_cnt = 2'd3;
            end else begin
                err_code = ST_BAD_UTF8;
            end
        end else begin
            if ((b & 8'hC0) != 8'h80) begin
                err_code = ST_BAD_UTF8;
            end else begin
                accum    = {accum[CODE_W-7:0], b[5:0]};
                need_cnt = need_cnt - 2'd1;
                if (need_cnt == 0) begin
                    cv   = accum;
                    have = 1'b1;
                end
            end
        end
        // range check and end of string
        if (have && cur_mode == MODE_UCS2 && cv > UCS2_MAX) begin
            err_code = ST_RANGE;
            have     = 1'b0;
        end
        if (err_code == ST_OK && last && !have)
            err_code = ST_BAD_UTF8;
        if (have)
            push_unit(cv, ST_OK, last);
        if (err_code != ST_OK && last)
            push_unit('0, err_code, 1'b1);
        if (last)
            clear_string();
    endtask

    // compare one output beat with the oldest expected code unit
    task automatic check_code_unit(input t_out_beat got);
        t_out_beat want;
        if (code_unit_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
                $display("unexpected beat: code %h status %0d eos %0d",
                         got.code_value, got.status, got.end_of_string);
            return;
        end
        want = code_unit_q.pop_front();
        if (got.code_value != want.code_value || got.status != want.status ||
            got.end_of_string != want.end_of_string) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX)
                $display("mismatch: expected code %h status %0d eos %0d, got code %h status %0d eos %0d",
                         want.code_value, want.status, want.end_of_string,
                         got.code_value, got.status, got.end_of_string);
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                decode_byte(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= byte_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor, with the long hold counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_code_unit(o_out_data);
            if (hold_req)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("utf8_to_ucs_transcoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push_item(logic [7:0] b, logic last);
        t_in_beat beat;
        beat.in_byte = b;
        beat.is_last = last;
        byte_q.push_back(beat);
    endfunction

    function automatic logic [7:0] pick_byte(int unsigned lo, int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[7:0];
    endfunction

    // one random string: mostly well-formed sequences, some noise bytes
    task automatic queue_string(output int unsigned count);
        logic [7:0]  s[$];
        int unsigned n_cp;
        int unsigned kind;
        int unsigned k;
        n_cp = $urandom_range(6, 1);
        for (k = 0; k < n_cp; k++) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
                s.push_back(QUOTE_BYTE);
                if ($urandom_range(1) == 1)
                    s.push_back(QUOTE_BYTE);
            end else if (kind < 38) begin
                s.push_back(pick_byte(8'h00, 8'h7F));
            end else if (kind < 56) begin
                s.push_back(pick_byte(8'hC0, 8'hDF));
                s.push_back(pick_byte(8'h80, 8'hBF));
            end else if (kind < 72) begin
                s.push_back(pick_byte(8'hE0, 8'hEF));
                s.push_back(pick_byte(8'h80, 8'hBF));
                s.push_back(pick_byte(8'h80, 8'hBF));
            end else if (kind < 86) begin
                s.push_back(pick_byte(8'hF0, 8'hF7));
                s.push_back(pick_byte(8'h80, 8'hBF));
                s.push_back(pick_byte(8'h80, 8'hBF));
                s.push_back(pick_byte(8'h80, 8'hBF));
            end else if (kind < 94) begin
                s.push_back(pick_byte(8'h00, 8'hFF));
            end else begin
                // lead byte cut short
                s.push_back(pick_byte(8'hC0, 8'hF7));
            end
        end
        for (k = 0; k < s.size(); k++)
            push_item(s[k], k == s.size() - 1);
        count = s.size();
    endtask

    // wait until every pending byte is taken and every result has come
    task automatic drain_all();
        while (byte_q.size() != 0 || i_in_valid || code_unit_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        drain_all();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        cur_mode = m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic [MODE_W-1:0] m, input int unsigned send_pct,
                                input int unsigned stall_pct, input int unsigned n_items);
        int unsigned done;
        int unsigned cnt;
        set_mode(m);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items) begin
            queue_string(cnt);
            done += cnt;
            // sender pauses once until the block is empty
            if (done >= n_items / 2 && done - cnt < n_items / 2)
                drain_all();
        end
    endtask

    // stimulus
    initial begin
        int unsigned ph;
        logic [MODE_W-1:0] modes[8];
        int unsigned send_set[4];
        int unsigned stall_set[4];
        modes     = '{MODE_UCS4, MODE_UCS2, MODE_RAW, MODE_UCS4,
                      MODE_UCS2, MODE_UNUSED, MODE_UCS4, MODE_UCS2};
        send_set  = '{0, 47, 0, 13};
        stall_set = '{0, 0, 47, 13};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: quotes, longest sequence, each error kind
        set_mode(MODE_UCS4);
        push_item(QUOTE_BYTE, 1'b0); push_item(QUOTE_BYTE, 1'b0); push_item(8'h41, 1'b1);
        push_item(QUOTE_BYTE, 1'b0); push_item(8'h00, 1'b1);
        push_item(QUOTE_BYTE, 1'b1);
        push_item(8'hF7, 1'b0); push_item(8'hBF, 1'b0);
        push_item(8'hBF, 1'b0); push_item(8'hBF, 1'b1);
        push_item(8'hC3, 1'b0); push_item(QUOTE_BYTE, 1'b1);
        push_item(8'hFF, 1'b0); push_item(8'h41, 1'b1);
        push_item(8'hE2, 1'b0); push_item(8'h82, 1'b1);
        // leave a sequence open across a mode change
        push_item(8'hE2, 1'b0);
        set_mode(MODE_RAW);
        push_item(8'h41, 1'b1);
        set_mode(MODE_UCS2);
        push_item(8'hEF, 1'b0); push_item(8'hBF, 1'b0); push_item(8'hBF, 1'b1);
        push_item(8'hF0, 1'b0); push_item(8'h9F, 1'b0);
        push_item(8'h98, 1'b0); push_item(8'h80, 1'b1);
        set_mode(MODE_UNUSED);
        push_item(8'hFF, 1'b1);

        // random phases over modes and idling patterns
        for (ph = 0; ph < 8; ph++)
            random_phase(modes[ph], send_set[ph % 4], stall_set[ph % 4], 225);

        // long receiver hold while the sender keeps offering
        random_phase(MODE_UCS4, 0, 0, 120);
        @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;

        drain_all();
        if (fail_cnt == 0 && code_unit_q.size() == 0)
            $display("utf8_to_ucs_transcoder verification clean");
        else
            $display("utf8_to_ucs_transcoder verification failed");
        $finish;
    end

endmodule

FILE: utf8_to_ucs_transcoder.f
hw/rtl/u2u_pkg.sv
hw/rtl/u2u_decode.sv
hw/rtl/u2u_outq.sv
hw/rtl/utf8_to_ucs_transcoder.sv
hw/rtl/u2u_checker.sv
tb/testbench.sv
